FILE: hw/rtl/sensor_frame_deframer_unit_defines.svh
// Assertion helpers for the deframer. The clock is clk and the reset is rst_n
// in every file that uses them.
`ifndef SENSOR_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define SENSOR_FRAME_DEFRAMER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// cons must hold in the same cycle as ante
`define SFD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// cons must hold in the cycle after ante
`define SFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`else

`define SFD_ASSERT_IMPL(lbl, ante, cons)
`define SFD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hw/rtl/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int FRAME_BYTES   = 24;
  localparam int POS_W         = $clog2(FRAME_BYTES);
  localparam int CHECK_POS     = 22;
  localparam int TAIL_POS      = 23;
  localparam int PAYLOAD_FIRST = 2;
  localparam int PAYLOAD_COUNT = 20;
  localparam int VALUE_COUNT   = 10;
  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 16;
  localparam int CFG_INDEX_W   = 8;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL   = 8'd1;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd123;
  localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'd125;

  // word slots in a frame, in arrival order
  localparam int IDX_VEL_X   = 0;
  localparam int IDX_VEL_Y   = 1;
  localparam int IDX_VEL_Z   = 2;
  localparam int IDX_ACCEL_X = 3;
  localparam int IDX_ACCEL_Y = 4;
  localparam int IDX_ACCEL_Z = 5;
  localparam int IDX_GYRO_X  = 6;
  localparam int IDX_GYRO_Y  = 7;
  localparam int IDX_GYRO_Z  = 8;
  localparam int IDX_VOLTAGE = 9;

  typedef enum logic [1:0] {
    ST_GOOD         = 2'd0,
    ST_BAD_HEADER   = 2'd1,
    ST_BAD_TAIL     = 2'd2,
    ST_BAD_CHECKSUM = 2'd3
  } frame_status_t;

  typedef logic [VALUE_COUNT-1:0][WORD_W-1:0] value_set_t;

  typedef struct packed {
    frame_status_t status;
    value_set_t    words;
  } frame_rec_t;

  typedef struct packed {
    logic                   valid;
    logic [CFG_INDEX_W-1:0] index;
    logic [BYTE_W-1:0]      data;
  } cfg_wr_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             frame_end;
  } front_stat_t;

  typedef struct packed {
    logic load;
    logic good;
  } back_stat_t;

endpackage

FILE: hw/rtl/sfd_front.sv
`timescale 1ns / 1ps

// Byte intake: position count, running XOR, header check, payload capture, classification.
module sfd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic [sfd_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                       in_full,
  input  sfd_pkg::cfg_wr_t           cfg_wr,
  input  logic                       q_full,
  output logic                       q_push,
  output sfd_pkg::frame_rec_t        q_rec,
  output sfd_pkg::front_stat_t       stat
);

  localparam int POS_W = sfd_pkg::POS_W;

  logic [sfd_pkg::BYTE_W-1:0] header_r, tail_r;
  logic [POS_W-1:0]           pos_r;
  logic [sfd_pkg::BYTE_W-1:0] xor_r;
  logic                       hdr_ok_r;
  logic [sfd_pkg::BYTE_W-1:0] payload_r [sfd_pkg::PAYLOAD_COUNT];

  logic                       is_tail;
  logic                       accept;
  logic [POS_W-1:0]           pos_nxt;
  logic [sfd_pkg::BYTE_W-1:0] xor_nxt;
  logic                       hdr_ok_nxt;

  assign is_tail = (pos_r == POS_W'(sfd_pkg::TAIL_POS));
  assign in_full = is_tail && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = accept && is_tail;

  always_comb begin
    pos_nxt    = pos_r;
    xor_nxt    = xor_r;
    hdr_ok_nxt = hdr_ok_r;
    if (accept) begin
      if (is_tail) begin
        pos_nxt    = '0;
        xor_nxt    = '0;
        hdr_ok_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        xor_nxt = xor_r ^ in_rx_byte;
        if (pos_r == '0) begin
          hdr_ok_nxt = (in_rx_byte == header_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      xor_r    <= '0;
      hdr_ok_r <= 1'b0;
      header_r <= sfd_pkg::HEADER_RESET;
      tail_r   <= sfd_pkg::TAIL_RESET;
    end else begin
      pos_r    <= pos_nxt;
      xor_r    <= xor_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      if (cfg_wr.valid && cfg_wr.index == sfd_pkg::REG_HEADER) begin
        header_r <= cfg_wr.data;
      end
      if (cfg_wr.valid && cfg_wr.index == sfd_pkg::REG_TAIL) begin
        tail_r <= cfg_wr.data;
      end
    end
  end

  // each payload slot is written at its own frame position
  for (genvar i = 0; i < sfd_pkg::PAYLOAD_COUNT; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (accept && pos_r == POS_W'(sfd_pkg::PAYLOAD_FIRST + i)) begin
        payload_r[i] <= in_rx_byte;
      end
    end
  end

  // classification on the tail byte; XOR already includes the check byte
  always_comb begin
    if (!hdr_ok_r) begin
      q_rec.status = sfd_pkg::ST_BAD_HEADER;
    end else if (in_rx_byte != tail_r) begin
      q_rec.status = sfd_pkg::ST_BAD_TAIL;
    end else if (xor_r != '0) begin
      q_rec.status = sfd_pkg::ST_BAD_CHECKSUM;
    end else begin
      q_rec.status = sfd_pkg::ST_GOOD;
    end
    for (int w = 0; w < sfd_pkg::VALUE_COUNT; w++) begin
      q_rec.words[w] = {payload_r[2*w], payload_r[2*w+1]};
    end
  end

  assign stat.pos       = pos_r;
  assign stat.frame_end = q_push;

endmodule

FILE: hw/rtl/sfd_queue.sv
`timescale 1ns / 1ps

// Small register FIFO between front and back.
module sfd_queue #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/sfd_back.sv
`timescale 1ns / 1ps

// Result stage: holds last good values, owns the output register.
module sfd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  sfd_pkg::frame_rec_t   q_data,
  output logic                  q_pop,
  input  logic                  out_pop,
  output logic                  out_empty,
  output sfd_pkg::frame_status_t status,
  output sfd_pkg::value_set_t   values,
  output sfd_pkg::back_stat_t   stat
);

  logic                   out_valid_r, out_valid_nxt;
  sfd_pkg::frame_status_t status_r;
  sfd_pkg::value_set_t    values_r;
  logic                   load;

  // slot free, or its request leaves this cycle
  assign load          = !q_empty && (!out_valid_r || out_pop);
  assign q_pop         = load;
  assign out_valid_nxt = load || (out_valid_r && !out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      values_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load && q_data.status == sfd_pkg::ST_GOOD) begin
        values_r <= q_data.words;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= q_data.status;
    end
  end

  assign out_empty = !out_valid_r;
  assign status    = status_r;
  assign values    = values_r;
  assign stat.load = load;
  assign stat.good = (q_data.status == sfd_pkg::ST_GOOD);

endmodule

FILE: hw/rtl/sensor_frame_deframer_unit.sv
`timescale 1ns / 1ps

// Sensor frame deframer. Serial bytes are pushed in one per request and
// grouped into fixed 24-byte frames counted from reset; there is no
// resynchronisation, so a lost or extra byte shifts every later frame.
// Byte 0 must match the header register, byte 23 the tail register, and
// the XOR of bytes 0..22 must be zero. Each completed frame yields one
// result request: a status (good, bad header, bad tail, checksum mismatch,
// first fault wins in that order) plus ten big-endian signed words taken
// from bytes 2..21. A bad frame leaves the held words as they were; before
// the first good frame they read zero.
// Rate: one byte per cycle while in_full is low. in_full rises only on the
// tail byte of a frame, and only when the frame queue between the intake
// and the result stage is full, i.e. when FRAME_QUEUE_DEPTH results plus
// the one in the output register are all waiting to be popped. A result is
// written into the queue on the edge that accepts its tail byte and moves
// into the output register once that register is empty or being popped.
// Registers are written through the cfg_ port, which is always ready;
// index 0 is the header byte, 1 the tail byte, anything else is ignored.
// The header is checked against the value held when byte 0 arrives and
// the tail against the value held when byte 23 arrives.
`include "sensor_frame_deframer_unit_defines.svh"

module sensor_frame_deframer_unit #(
  parameter int FRAME_QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // byte intake
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [sfd_pkg::BYTE_W-1:0]      in_rx_byte,
  // frame results
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [1:0]                      out_frame_status,
  output logic signed [sfd_pkg::WORD_W-1:0] out_vel_x,
  output logic signed [sfd_pkg::WORD_W-1:0] out_vel_y,
  output logic signed [sfd_pkg::WORD_W-1:0] out_vel_z,
  output logic signed [sfd_pkg::WORD_W-1:0] out_accel_x,
  output logic signed [sfd_pkg::WORD_W-1:0] out_accel_y,
  output logic signed [sfd_pkg::WORD_W-1:0] out_accel_z,
  output logic signed [sfd_pkg::WORD_W-1:0] out_gyro_x,
  output logic signed [sfd_pkg::WORD_W-1:0] out_gyro_y,
  output logic signed [sfd_pkg::WORD_W-1:0] out_gyro_z,
  output logic signed [sfd_pkg::WORD_W-1:0] out_supply_voltage,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfd_pkg::BYTE_W-1:0]      cfg_data
);

  localparam int REC_W = $bits(sfd_pkg::frame_rec_t);

  sfd_pkg::cfg_wr_t       cfg_wr;
  sfd_pkg::frame_rec_t    front_rec, q_rec;
  sfd_pkg::front_stat_t   front_st;
  sfd_pkg::back_stat_t    back_st;
  sfd_pkg::frame_status_t status;
  sfd_pkg::value_set_t    values;
  logic                   q_push, q_full, q_pop, q_empty;
  logic [REC_W-1:0]       q_rd_bits;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // intake and classification
  sfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .cfg_wr     (cfg_wr),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_rec      (front_rec),
    .stat       (front_st)
  );

  // completed frames wait here while the output side stalls
  sfd_queue #(
    .DEPTH (FRAME_QUEUE_DEPTH),
    .WIDTH (REC_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_rec),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rd_bits),
    .empty     (q_empty)
  );

  assign q_rec = sfd_pkg::frame_rec_t'(q_rd_bits);

  // held values and output register
  sfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rec),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .status    (status),
    .values    (values),
    .stat      (back_st)
  );

  assign out_frame_status   = status;
  assign out_vel_x          = $signed(values[sfd_pkg::IDX_VEL_X]);
  assign out_vel_y          = $signed(values[sfd_pkg::IDX_VEL_Y]);
  assign out_vel_z          = $signed(values[sfd_pkg::IDX_VEL_Z]);
  assign out_accel_x        = $signed(values[sfd_pkg::IDX_ACCEL_X]);
  assign out_accel_y        = $signed(values[sfd_pkg::IDX_ACCEL_Y]);
  assign out_accel_z        = $signed(values[sfd_pkg::IDX_ACCEL_Z]);
  assign out_gyro_x         = $signed(values[sfd_pkg::IDX_GYRO_X]);
  assign out_gyro_y         = $signed(values[sfd_pkg::IDX_GYRO_Y]);
  assign out_gyro_z         = $signed(values[sfd_pkg::IDX_GYRO_Z]);
  assign out_supply_voltage = $signed(values[sfd_pkg::IDX_VOLTAGE]);

  // a frame never ends into a full queue, and the count restarts after it
  `SFD_ASSERT_IMPL(a_queue_room, front_st.frame_end, !q_full)
  `SFD_ASSERT_NEXT(a_frame_wrap, front_st.frame_end, front_st.pos == '0)
  // a rejected frame leaves the held values alone
  `SFD_ASSERT_NEXT(a_bad_holds, back_st.load && !back_st.good, $stable(values))

endmodule

FILE: tb/tb_sensor_frame_deframer_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for the byte deframer. Bytes are pushed, frames popped.
module tb_sensor_frame_deframer_unit;

  localparam int QUIET_LIMIT      = 2000; // cycles in which no request completes
  localparam int FRAMES_PER_PHASE = 4;
  localparam int DRAIN_CYCLES     = 8;    // spare cycles once every result has been popped
  localparam int IDX_W            = sfd_pkg::CFG_INDEX_W;

  // frame shapes the stimulus can build; the model decides what comes out
  typedef enum int {
    FRAME_CLEAN,
    FRAME_BAD_HEADER,
    FRAME_BAD_TAIL,
    FRAME_BAD_SUM,
    FRAME_HEADER_TAIL,
    FRAME_TAIL_SUM,
    FRAME_ALL_BAD
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_rx_byte = '0;

  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_frame_status;
  logic signed [sfd_pkg::WORD_W-1:0] out_vel_x, out_vel_y, out_vel_z;
  logic signed [sfd_pkg::WORD_W-1:0] out_accel_x, out_accel_y, out_accel_z;
  logic signed [sfd_pkg::WORD_W-1:0] out_gyro_x, out_gyro_y, out_gyro_z;
  logic signed [sfd_pkg::WORD_W-1:0] out_supply_voltage;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [IDX_W-1:0]          cfg_index = '0;
  logic [sfd_pkg::BYTE_W-1:0] cfg_data = '0;

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sensor_frame_deframer_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_rx_byte         (in_rx_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_frame_status   (out_frame_status),
    .out_vel_x          (out_vel_x),
    .out_vel_y          (out_vel_y),
    .out_vel_z          (out_vel_z),
    .out_accel_x        (out_accel_x),
    .out_accel_y        (out_accel_y),
    .out_accel_z        (out_accel_z),
    .out_gyro_x         (out_gyro_x),
    .out_gyro_y         (out_gyro_y),
    .out_gyro_z         (out_gyro_z),
    .out_supply_voltage (out_supply_voltage),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  string word_name [sfd_pkg::VALUE_COUNT] = '{"vel_x", "vel_y", "vel_z", "accel_x",
                                              "accel_y", "accel_z", "gyro_x", "gyro_y",
                                              "gyro_z", "supply_voltage"};

  // --- deframer model: own copy of registers and frame state ---
  logic [7:0] header_reg = sfd_pkg::HEADER_RESET;
  logic [7:0] tail_reg   = sfd_pkg::TAIL_RESET;
  int         frame_pos  = 0;
  logic [7:0] frame_xor  = '0;
  logic       header_ok  = 1'b0;
  logic [7:0] payload [sfd_pkg::PAYLOAD_COUNT];
  sfd_pkg::value_set_t held_words = '0;   // last good frame's words, zero until one arrives

  sfd_pkg::frame_rec_t expected_frames [$];

  // stimulus side
  logic [7:0] byte_queue [$];
  int         queued_bytes = 0;  // for frame alignment of the plan

  // bookkeeping
  int handshakes     = 0;
  int errors         = 0;
  int bytes_taken    = 0;
  int frames_checked = 0;
  int cfg_writes     = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  int push_gap = 0, push_calm = 0;
  int pop_stall = 0, pop_calm = 0;

  // per-request wait drawn at random, with the odd stretch of back-to-back requests
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  function automatic void note_mismatch(string what);
    errors++;
    if (errors <= 10)
      $display("MISMATCH at %0t: %s", $realtime, what);
  endfunction

  // One accepted byte through the model. Header checked against the
  // register at byte 0, tail at byte 23; XOR covers 0..22 so a good
  // checksum leaves it zero.
  function automatic void advance_deframe(logic [7:0] b);
    sfd_pkg::frame_rec_t rec;
    int                  k;
    if (frame_pos < sfd_pkg::TAIL_POS)
      frame_xor = frame_xor ^ b;
    if (frame_pos == 0)
      header_ok = (b == header_reg);
    if (frame_pos >= sfd_pkg::PAYLOAD_FIRST &&
        frame_pos < sfd_pkg::PAYLOAD_FIRST + sfd_pkg::PAYLOAD_COUNT)
      payload[frame_pos - sfd_pkg::PAYLOAD_FIRST] = b;
    if (frame_pos != sfd_pkg::TAIL_POS) begin
      frame_pos++;
      return;
    end
    // first fault wins: header, then tail, then checksum
    if (!header_ok)
      rec.status = sfd_pkg::ST_BAD_HEADER;
    else if (b != tail_reg)
      rec.status = sfd_pkg::ST_BAD_TAIL;
    else if (frame_xor != 8'h00)
      rec.status = sfd_pkg::ST_BAD_CHECKSUM;
    else
      rec.status = sfd_pkg::ST_GOOD;
    if (rec.status == sfd_pkg::ST_GOOD)
      for (k = 0; k < sfd_pkg::VALUE_COUNT; k++)
        held_words[k] = {payload[2*k], payload[2*k+1]};   // big-endian
    rec.words = held_words;
    expected_frames.push_back(rec);
    frame_pos = 0;
    frame_xor = '0;
    header_ok = 1'b0;
  endfunction

  // --- byte driver: one request per accepted byte ---
  always @(posedge clk) begin : byte_driver
    logic       nxt_push;
    logic [7:0] nxt_byte;
    nxt_push = in_push;
    nxt_byte = in_rx_byte;
    if (rst_n) begin
      if (in_push && !in_full) begin
        advance_deframe(in_rx_byte);
        bytes_taken++;
        handshakes++;
        nxt_push = 1'b0;
      end
      // byte held steady while in_full stalls it
      if (!nxt_push) begin
        if (push_gap > 0)
          push_gap--;
        else if (byte_queue.size() != 0) begin
          nxt_byte = byte_queue.pop_front();
          nxt_push = 1'b1;
          push_gap = draw_wait(push_calm);
        end
      end
    end
    in_push    <= nxt_push;
    in_rx_byte <= nxt_byte;
  end

  // --- result monitor: pops with random stalls, checks every field ---
  always @(posedge clk) begin : result_monitor
    logic                nxt_pop;
    sfd_pkg::value_set_t got;
    sfd_pkg::frame_rec_t want;
    int                  k;
    nxt_pop = out_pop;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        handshakes++;
        got[sfd_pkg::IDX_VEL_X]   = out_vel_x;
        got[sfd_pkg::IDX_VEL_Y]   = out_vel_y;
        got[sfd_pkg::IDX_VEL_Z]   = out_vel_z;
        got[sfd_pkg::IDX_ACCEL_X] = out_accel_x;
        got[sfd_pkg::IDX_ACCEL_Y] = out_accel_y;
        got[sfd_pkg::IDX_ACCEL_Z] = out_accel_z;
        got[sfd_pkg::IDX_GYRO_X]  = out_gyro_x;
        got[sfd_pkg::IDX_GYRO_Y]  = out_gyro_y;
        got[sfd_pkg::IDX_GYRO_Z]  = out_gyro_z;
        got[sfd_pkg::IDX_VOLTAGE] = out_supply_voltage;
        if (expected_frames.size() == 0)
          note_mismatch($sformatf("result popped with none expected (status %0d)",
                                  out_frame_status));
        else begin
          want = expected_frames.pop_front();
          frames_checked++;
          status_seen[want.status]++;
          if (out_frame_status !== want.status)
            note_mismatch($sformatf("frame %0d status: expected %0d, got %0d",
                                    frames_checked, want.status, out_frame_status));
          for (k = 0; k < sfd_pkg::VALUE_COUNT; k++)
            if (got[k] !== want.words[k])
              note_mismatch($sformatf("frame %0d %s: expected %0d, got %0d",
                                      frames_checked, word_name[k],
                                      $signed(want.words[k]), $signed(got[k])));
        end
        nxt_pop   = 1'b0;
        pop_stall = draw_wait(pop_calm);
      end
      if (!nxt_pop) begin
        if (pop_stall > 0)
          pop_stall--;
        else
          nxt_pop = 1'b1;
      end
    end
    out_pop <= nxt_pop;
  end

  // --- watchdog: ends the run if no request completes for too long ---
  always @(negedge clk) begin : watchdog
    int seen;
    int quiet;
    if (handshakes != seen) begin
      seen  = handshakes;
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout: no request for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --- stimulus planning ---
  function automatic void queue_byte(logic [7:0] b);
    byte_queue.push_back(b);
    queued_bytes++;
  endfunction

  // pad with noise up to the next frame boundary
  function automatic void realign();
    while (queued_bytes % sfd_pkg::FRAME_BYTES != 0)
      queue_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic sfd_pkg::value_set_t random_words();
    sfd_pkg::value_set_t w;
    int                  k;
    for (k = 0; k < sfd_pkg::VALUE_COUNT; k++)
      case ($urandom_range(0, 7))
        0:       w[k] = 16'h8000;
        1:       w[k] = 16'h7FFF;
        2:       w[k] = 16'h0000;
        3:       w[k] = 16'hFFFF;
        default: w[k] = 16'($urandom_range(0, 65535));
      endcase
    return w;
  endfunction

  // Builds one aligned frame against the current registers. A bad header
  // is folded into the checksum so that only the header is at fault.
  function automatic void queue_frame(frame_kind_t kind, sfd_pkg::value_set_t words,
                                      logic [7:0] b1);
    logic [7:0] f [sfd_pkg::FRAME_BYTES];
    logic [7:0] sum;
    int         k;
    f[0] = header_reg;
    f[1] = b1;
    for (k = 0; k < sfd_pkg::VALUE_COUNT; k++) begin
      f[sfd_pkg::PAYLOAD_FIRST + 2*k]     = words[k][15:8];
      f[sfd_pkg::PAYLOAD_FIRST + 2*k + 1] = words[k][7:0];
    end
    if (kind == FRAME_BAD_HEADER || kind == FRAME_HEADER_TAIL || kind == FRAME_ALL_BAD)
      f[0] = f[0] ^ 8'($urandom_range(1, 255));
    sum = '0;
    for (k = 0; k < sfd_pkg::CHECK_POS; k++)
      sum = sum ^ f[k];
    f[sfd_pkg::CHECK_POS] = sum;
    f[sfd_pkg::TAIL_POS]  = tail_reg;
    if (kind == FRAME_BAD_TAIL || kind == FRAME_HEADER_TAIL || kind == FRAME_TAIL_SUM ||
        kind == FRAME_ALL_BAD)
      f[sfd_pkg::TAIL_POS] = f[sfd_pkg::TAIL_POS] ^ 8'($urandom_range(1, 255));
    if (kind == FRAME_BAD_SUM || kind == FRAME_TAIL_SUM || kind == FRAME_ALL_BAD)
      f[sfd_pkg::CHECK_POS] = f[sfd_pkg::CHECK_POS] ^ 8'($urandom_range(1, 255));
    for (k = 0; k < sfd_pkg::FRAME_BYTES; k++)
      queue_byte(f[k]);
  endfunction

  // Mostly well-formed frames with random content, some faulty ones, and
  // now and then a burst of stray bytes padded out to a junk frame.
  task automatic random_phase();
    int made;
    int r;
    int n;
    frame_kind_t kind;
    made = 0;
    @(negedge clk);
    while (made < FRAMES_PER_PHASE) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        n = $urandom_range(1, 5);
        repeat (n) queue_byte(8'($urandom_range(0, 255)));
        realign();
      end else begin
        if (r < 60)      kind = FRAME_CLEAN;
        else if (r < 70) kind = FRAME_BAD_HEADER;
        else if (r < 78) kind = FRAME_BAD_TAIL;
        else if (r < 86) kind = FRAME_BAD_SUM;
        else if (r < 89) kind = FRAME_HEADER_TAIL;
        else if (r < 92) kind = FRAME_TAIL_SUM;
        else             kind = FRAME_ALL_BAD;
        queue_frame(kind, random_words(), 8'($urandom_range(0, 255)));
        made++;
      end
    end
  endtask

  // all bytes in, all results out, then a few spare cycles
  task automatic wait_drained();
    @(negedge clk);
    while (byte_queue.size() != 0 || in_push || expected_frames.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write request; model copy updated at the handshake
  task automatic write_reg(logic [IDX_W-1:0] index, logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (index == sfd_pkg::REG_HEADER)
      header_reg = data;
    else if (index == sfd_pkg::REG_TAIL)
      tail_reg = data;
    cfg_writes++;
    handshakes++;
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    sfd_pkg::value_set_t ext_a;
    sfd_pkg::value_set_t ext_b;
    logic [7:0]          same;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames under reset register values
    ext_a = {16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
             16'hFFFE, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000};
    ext_b = ~ext_a;
    @(negedge clk);
    queue_frame(FRAME_BAD_SUM, ext_b, 8'h00);     // no good frame yet: words read zero
    queue_frame(FRAME_CLEAN, ext_a, 8'h00);
    queue_frame(FRAME_CLEAN, ext_b, 8'hFF);       // byte 1 only feeds the checksum
    queue_frame(FRAME_BAD_HEADER, ext_a, 8'($urandom_range(0, 255)));
    queue_frame(FRAME_BAD_TAIL, ext_a, 8'($urandom_range(0, 255)));
    queue_frame(FRAME_HEADER_TAIL, ext_a, 8'($urandom_range(0, 255)));
    queue_frame(FRAME_TAIL_SUM, ext_a, 8'($urandom_range(0, 255)));
    queue_frame(FRAME_ALL_BAD, ext_a, 8'($urandom_range(0, 255)));
    wait_drained();

    // register extremes, plus writes to unused indexes that must be ignored
    write_reg(sfd_pkg::REG_HEADER, 8'h00);
    write_reg(sfd_pkg::REG_TAIL, 8'hFF);
    write_reg(IDX_W'(sfd_pkg::REG_TAIL + 1), 8'($urandom_range(0, 255)));
    random_phase();
    wait_drained();

    write_reg(sfd_pkg::REG_HEADER, 8'hFF);
    write_reg(sfd_pkg::REG_TAIL, 8'h00);
    write_reg({IDX_W{1'b1}}, 8'($urandom_range(0, 255)));
    random_phase();
    wait_drained();

    write_reg(sfd_pkg::REG_HEADER, 8'($urandom_range(0, 255)));
    write_reg(sfd_pkg::REG_TAIL, 8'($urandom_range(0, 255)));
    write_reg(IDX_W'($urandom_range(sfd_pkg::REG_TAIL + 1, 255)),
              8'($urandom_range(0, 255)));
    random_phase();
    wait_drained();

    // header and tail equal
    same = 8'($urandom_range(0, 255));
    write_reg(sfd_pkg::REG_HEADER, same);
    write_reg(sfd_pkg::REG_TAIL, same);
    random_phase();
    wait_drained();

    write_reg(sfd_pkg::REG_HEADER, sfd_pkg::HEADER_RESET);
    write_reg(sfd_pkg::REG_TAIL, sfd_pkg::TAIL_RESET);
    random_phase();
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d bytes in %0d frames: %0d good, %0d bad header, %0d bad tail,",
             bytes_taken, frames_checked, status_seen[sfd_pkg::ST_GOOD],
             status_seen[sfd_pkg::ST_BAD_HEADER], status_seen[sfd_pkg::ST_BAD_TAIL]);
    $display("%0d checksum faults, %0d register writes, %0d mismatches.",
             status_seen[sfd_pkg::ST_BAD_CHECKSUM], cfg_writes, errors);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sensor_frame_deframer_unit.f
+incdir+hw/rtl
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_front.sv
hw/rtl/sfd_queue.sv
hw/rtl/sfd_back.sv
hw/rtl/sensor_frame_deframer_unit.sv
tb/tb_sensor_frame_deframer_unit.sv
